@@ design/pc_pkg.sv @@
// pc_pkg: shared widths and handshake structs for the correlation block
// depends on nothing
`default_nettype none
package pc_pkg;
    localparam int SAMPLE_W  = 16;
    localparam int COUNT_W   = 17;
    localparam int SUM_W     = 33;
    localparam int SQ_W      = 48;
    localparam int MUL_W     = 32;
    localparam int WORD_W    = 64;
    localparam int PROD_W    = 128;
    localparam int QUOT_W    = 31;
    localparam int ROOT_W    = 16;
    localparam int MAX_PAIRS = 65536;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;
endpackage
`default_nettype wire

@@ design/pc_mul.sv @@
// pc_mul: shared 32x32 unsigned multiplier with registered product
// depends on pc_pkg
`default_nettype none
module pc_mul (
    input  wire logic                          i_clk,
    input  wire logic [pc_pkg::MUL_W-1:0]      i_a,
    input  wire logic [pc_pkg::MUL_W-1:0]      i_b,
    output logic      [2*pc_pkg::MUL_W-1:0]    o_p
);
    import pc_pkg::*;

    logic [2*MUL_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

@@ design/pc_div.sv @@
// pc_div: restoring divider, one quotient bit a cycle
// quotient of (num * 2^30) / den, where num <= den; depends on pc_pkg
`default_nettype none
module pc_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire pc_pkg::t_div_ctl              i_ctl,
    input  wire logic [pc_pkg::PROD_W-1:0]     i_num,
    input  wire logic [pc_pkg::PROD_W-1:0]     i_den,
    output pc_pkg::t_div_sts                   o_sts,
    output logic      [pc_pkg::QUOT_W-1:0]     o_quot
);
    import pc_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUOT_W - 1);

    logic [PROD_W-1:0] r_rem;
    logic [PROD_W-1:0] r_den;
    logic [QUOT_W-1:0] r_quot;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_b0;
    logic              r_busy;
    logic              r_done;

    logic [PROD_W:0]   trial;
    logic [PROD_W:0]   diff;
    logic              ge;

    always_comb begin
        trial = {r_rem, (r_cnt == '0) ? r_b0 : 1'b0};
        diff  = trial - {1'b0, r_den};
        ge    = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem  <= {1'b0, i_num[PROD_W-1:1]};
            r_b0   <= i_num[0];
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[PROD_W-1:0] : trial[PROD_W-1:0];
            r_quot <= {r_quot[QUOT_W-2:0], ge};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_quot;

    // remainder always below the divisor between steps
    a_rem_lt_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_cnt != '0 |-> r_rem < r_den)
        else $error("remainder not below divisor");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without busy");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> !r_busy)
        else $error("divider restarted while busy");
endmodule
`default_nettype wire

@@ design/pearson_correlation.sv @@
// pearson_correlation: running sums of paired samples and Pearson coefficient in Q1.15
// plain word: S_ACC0-S_ACC3 until o_ready, one shared 32x32 multiplier, three products
// last word: eight 64x64 products, then the divider and the bitwise square root; a series
// with zero or negative variance goes to S_FIN after six products; S_FIN waits on o_valid
// synchronous active-low reset clears the state, the count, the sums and o_valid
// depends on pc_pkg, pc_mul, pc_div
`default_nettype none
module pearson_correlation (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic signed [pc_pkg::SAMPLE_W-1:0] i_sample_x,
    input  wire logic signed [pc_pkg::SAMPLE_W-1:0] i_sample_y,
    input  wire logic                               i_last,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic signed      [pc_pkg::SAMPLE_W-1:0] o_correlation,
    output logic                                    o_degenerate
);
    import pc_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ACC0 = 4'd1;
    localparam logic [3:0] S_ACC1 = 4'd2;
    localparam logic [3:0] S_ACC2 = 4'd3;
    localparam logic [3:0] S_ACC3 = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_CHK  = 4'd6;
    localparam logic [3:0] S_DVS  = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_SQ   = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;

    localparam logic [2:0] J_NXY = 3'd0;
    localparam logic [2:0] J_XY  = 3'd1;
    localparam logic [2:0] J_NXX = 3'd2;
    localparam logic [2:0] J_XX  = 3'd3;
    localparam logic [2:0] J_NYY = 3'd4;
    localparam logic [2:0] J_YY  = 3'd5;
    localparam logic [2:0] J_MAG = 3'd6;
    localparam logic [2:0] J_DEN = 3'd7;

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_PAIRS);
    localparam logic [QUOT_W-1:0]  QUOT_MAX  = QUOT_W'(1) << (2 * ROOT_W - 2);
    localparam logic [ROOT_W-1:0]  POS_MAX   = {1'b0, {(ROOT_W-1){1'b1}}};
    localparam logic [ROOT_W-1:0]  NEG_MAX   = {1'b1, {(ROOT_W-1){1'b0}}};

    logic [3:0]                r_state, n_state;
    logic signed [SAMPLE_W-1:0] r_x, r_y;
    logic                      r_last, r_en;
    logic [COUNT_W-1:0]        r_count;
    logic [SUM_W-1:0]          r_sx, r_sy;
    logic [SQ_W-1:0]           r_sxx, r_syy, r_sxy;
    logic [2:0]                r_job, r_ph;
    logic [PROD_W-1:0]         r_acc;
    logic [WORD_W-1:0]         r_num, r_vx, r_vy;
    logic [PROD_W-1:0]         r_r, r_d;
    logic [QUOT_W-1:0]         r_qd;
    logic [ROOT_W-1:0]         r_q;
    logic [3:0]                r_bit;
    logic                      r_degen;
    logic                      r_ovalid, n_ovalid;
    logic [ROOT_W-1:0]         r_corr;
    logic                      r_odeg;

    logic [MUL_W-1:0]          mul_a, mul_b;
    logic [2*MUL_W-1:0]        mul_p;
    t_div_ctl                  div_ctl;
    t_div_sts                  div_sts;
    logic [QUOT_W-1:0]         div_q;

    logic [WORD_W-1:0]         opa, opb, ma, mb, mag, res;
    logic                      sgn;
    logic [PROD_W-1:0]         acc_sum;
    logic [ROOT_W-1:0]         cand;
    logic [SQ_W-1:0]           prod48;
    logic                      accept, load, degen_now;
    logic [ROOT_W-1:0]         corr_val;

    pc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    pc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_num   (r_r),
        .i_den   (r_d),
        .o_sts   (div_sts),
        .o_quot  (div_q)
    );

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign load    = (r_state == S_FIN) && (!r_ovalid || i_ready);
    assign div_ctl.start = (r_state == S_DVS);

    always_comb begin
        mag = r_num[WORD_W-1] ? (~r_num + 1'b1) : r_num;
        unique case (r_job)
            J_NXY: begin opa = WORD_W'(r_count); opb = WORD_W'(signed'(r_sxy)); end
            J_XY:  begin opa = WORD_W'(signed'(r_sx)); opb = WORD_W'(signed'(r_sy)); end
            J_NXX: begin opa = WORD_W'(r_count); opb = WORD_W'(r_sxx); end
            J_XX:  begin opa = WORD_W'(signed'(r_sx)); opb = WORD_W'(signed'(r_sx)); end
            J_NYY: begin opa = WORD_W'(r_count); opb = WORD_W'(r_syy); end
            J_YY:  begin opa = WORD_W'(signed'(r_sy)); opb = WORD_W'(signed'(r_sy)); end
            J_MAG: begin opa = mag; opb = mag; end
            J_DEN: begin opa = r_vx; opb = r_vy; end
            default: begin opa = '0; opb = '0; end
        endcase
        ma  = opa[WORD_W-1] ? (~opa + 1'b1) : opa;
        mb  = opb[WORD_W-1] ? (~opb + 1'b1) : opb;
        sgn = opa[WORD_W-1] ^ opb[WORD_W-1];
    end

    always_comb begin
        unique case (r_ph)
            3'd1:    acc_sum = r_acc + {{MUL_W*2{1'b0}}, mul_p};
            3'd2,
            3'd3:    acc_sum = r_acc + {{MUL_W{1'b0}}, mul_p, {MUL_W{1'b0}}};
            3'd4:    acc_sum = r_acc + {mul_p, {MUL_W*2{1'b0}}};
            default: acc_sum = '0;
        endcase
        res = sgn ? (~acc_sum[WORD_W-1:0] + 1'b1) : acc_sum[WORD_W-1:0];
    end

    always_comb begin
        cand   = r_q | (ROOT_W'(1) << r_bit);
        prod48 = SQ_W'(signed'(mul_p[MUL_W-1:0]));
        mul_a  = '0;
        mul_b  = '0;
        unique case (r_state)
            S_ACC0: begin
                mul_a = MUL_W'(r_x);
                mul_b = MUL_W'(r_x);
            end
            S_ACC1: begin
                mul_a = MUL_W'(r_y);
                mul_b = MUL_W'(r_y);
            end
            S_ACC2: begin
                mul_a = MUL_W'(r_x);
                mul_b = MUL_W'(r_y);
            end
            S_MUL: begin
                mul_a = r_ph[1] ? ma[WORD_W-1:MUL_W] : ma[MUL_W-1:0];
                mul_b = (r_ph == 3'd1 || r_ph == 3'd3) ? mb[WORD_W-1:MUL_W]
                                                       : mb[MUL_W-1:0];
            end
            S_SQ: begin
                mul_a = MUL_W'(cand);
                mul_b = MUL_W'(cand);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign degen_now = (r_vx == '0) || (r_vy == '0) || r_vx[WORD_W-1] || r_vy[WORD_W-1];

    always_comb begin
        if (r_degen) begin
            corr_val = '0;
        end else if (r_num[WORD_W-1]) begin
            corr_val = (r_q >= NEG_MAX) ? NEG_MAX : (~r_q + 1'b1);
        end else begin
            corr_val = (r_q > POS_MAX) ? POS_MAX : r_q;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_ACC0;
            S_ACC0: n_state = S_ACC1;
            S_ACC1: n_state = S_ACC2;
            S_ACC2: n_state = S_ACC3;
            S_ACC3: n_state = r_last ? S_MUL : S_IDLE;
            S_MUL: begin
                if (r_ph == 3'd4) begin
                    if (r_job == J_YY) n_state = S_CHK;
                    else if (r_job == J_DEN) n_state = S_DVS;
                end
            end
            S_CHK: n_state = degen_now ? S_FIN : S_MUL;
            S_DVS: n_state = S_DIV;
            S_DIV: if (div_sts.done) n_state = S_SQ;
            S_SQ:  if (r_ph[0] && r_bit == '0) n_state = S_FIN;
            S_FIN: if (load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (load) n_ovalid = 1'b1;
        else if (i_ready) n_ovalid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_count  <= '0;
            r_sx     <= '0;
            r_sy     <= '0;
            r_sxx    <= '0;
            r_syy    <= '0;
            r_sxy    <= '0;
            r_job    <= '0;
            r_ph     <= '0;
            r_degen  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (accept && r_count < COUNT_MAX) begin
                r_sx    <= r_sx + SUM_W'(i_sample_x);
                r_sy    <= r_sy + SUM_W'(i_sample_y);
                r_count <= r_count + 1'b1;
            end
            if (r_en) begin
                if (r_state == S_ACC1) r_sxx <= r_sxx + prod48;
                if (r_state == S_ACC2) r_syy <= r_syy + prod48;
                if (r_state == S_ACC3) r_sxy <= r_sxy + prod48;
            end
            if (r_state == S_ACC3) begin
                r_job <= J_NXY;
                r_ph  <= '0;
            end
            if (r_state == S_MUL) begin
                if (r_ph == 3'd4) begin
                    r_ph  <= '0;
                    r_job <= r_job + 1'b1;
                end else begin
                    r_ph <= r_ph + 1'b1;
                end
            end
            if (r_state == S_CHK) r_degen <= degen_now;
            if (r_state == S_DIV && div_sts.done) r_ph <= '0;
            if (r_state == S_SQ) r_ph <= {2'b00, ~r_ph[0]};
            if (load) begin
                r_count <= '0;
                r_sx    <= '0;
                r_sy    <= '0;
                r_sxx   <= '0;
                r_syy   <= '0;
                r_sxy   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x    <= i_sample_x;
            r_y    <= i_sample_y;
            r_last <= i_last;
            r_en   <= r_count < COUNT_MAX;
        end
        if (r_state == S_MUL) begin
            r_acc <= acc_sum;
            if (r_ph == 3'd4) begin
                unique case (r_job)
                    J_NXY:   r_num <= res;
                    J_XY:    r_num <= r_num - res;
                    J_NXX:   r_vx  <= res;
                    J_XX:    r_vx  <= r_vx - res;
                    J_NYY:   r_vy  <= res;
                    J_YY:    r_vy  <= r_vy - res;
                    J_MAG:   r_r   <= acc_sum;
                    J_DEN:   r_d   <= acc_sum;
                    default: r_num <= r_num;
                endcase
            end
        end
        if (r_state == S_DIV && div_sts.done) begin
            r_qd  <= div_q;
            r_q   <= '0;
            r_bit <= 4'(ROOT_W - 1);
        end
        if (r_state == S_SQ && r_ph[0]) begin
            if (mul_p <= (2*MUL_W)'(r_qd)) r_q <= cand;
            r_bit <= r_bit - 1'b1;
        end
        if (load) begin
            r_corr <= corr_val;
            r_odeg <= r_degen;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_correlation = signed'(r_corr);
    assign o_degenerate  = r_odeg;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_MAX)
        else $error("pair count beyond limit");
    a_ratio_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SQ |-> r_qd <= QUOT_MAX)
        else $error("squared ratio above one");
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_correlation == '0)
        else $error("degenerate word with nonzero correlation");
    a_sums_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_count == '0 && r_sx == '0 && r_sxy == '0)
        else $error("sums not cleared after result");
endmodule
`default_nettype wire

@@ bench/tb.sv @@
// tb: self-checking bench for pearson_correlation, directed table then random series
// predicts each result with exact wide integer arithmetic; depends on pc_pkg and the block
module tb;
    import pc_pkg::*;

    typedef struct {
        logic signed [SAMPLE_W-1:0] corr;
        logic                       degen;
    } t_corr;

    typedef struct {
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic                       last;
        bit                         typed;
        logic signed [SAMPLE_W-1:0] corr;
        logic                       degen;
    } t_row;

    localparam int WATCHDOG = 5000;
    localparam int HOLD_CYCLES = 400;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic signed [SAMPLE_W-1:0] i_sample_x;
    logic signed [SAMPLE_W-1:0] i_sample_y;
    logic                       i_last;
    logic                       o_valid;
    logic                       i_ready;
    logic signed [SAMPLE_W-1:0] o_correlation;
    logic                       o_degenerate;

    pearson_correlation uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_sample_x(i_sample_x), .i_sample_y(i_sample_y), .i_last(i_last),
        .o_valid(o_valid), .i_ready(i_ready), .o_correlation(o_correlation),
        .o_degenerate(o_degenerate)
    );

    // predictor state
    logic [COUNT_W-1:0]       acc_n;
    logic signed [SUM_W-1:0]  acc_x;
    logic signed [SUM_W-1:0]  acc_y;
    logic signed [SQ_W-1:0]   acc_xx;
    logic signed [SQ_W-1:0]   acc_yy;
    logic signed [SQ_W-1:0]   acc_xy;

    t_corr pending_corr[$];
    int    errors;
    int    idle_cycles;
    bit    calm;
    bit    hold_req;

    always begin
        #5 i_clk = 1'b0;
        #5 i_clk = 1'b1;
    end

    function automatic void clear_sums();
        acc_n = '0;
        acc_x = '0;
        acc_y = '0;
        acc_xx = '0;
        acc_yy = '0;
        acc_xy = '0;
    endfunction

    // takes one pair into the sums; returns 1 with the coefficient on last
    function automatic bit take_pair(input logic signed [SAMPLE_W-1:0] x,
                                     input logic signed [SAMPLE_W-1:0] y,
                                     input logic last, output t_corr res);
        logic signed [31:0] pxx, pyy, pxy;
        longint n, sx, sy, num;
        logic [63:0] vx, vy, mag;
        logic [191:0] rhs, den, tst, cc;
        logic [16:0] q, c;
        bit neg;
        pxx = x * x;
        pyy = y * y;
        pxy = x * y;
        if (acc_n < MAX_PAIRS) begin
            acc_x = acc_x + x;
            acc_y = acc_y + y;
            acc_xx = acc_xx + pxx;
            acc_yy = acc_yy + pyy;
            acc_xy = acc_xy + pxy;
            acc_n = acc_n + 1'b1;
        end
        if (!last) return 1'b0;
        n = acc_n;
        sx = acc_x;
        sy = acc_y;
        num = n * longint'(acc_xy) - sx * sy;
        vx = n * longint'(acc_xx) - sx * sx;
        vy = n * longint'(acc_yy) - sy * sy;
        clear_sums();
        if (vx == 0 || vy == 0 || vx[63] || vy[63]) begin
            res.corr = '0;
            res.degen = 1'b1;
            return 1'b1;
        end
        neg = num < 0;
        mag = neg ? -num : num;
        rhs = mag;
        rhs = (rhs * rhs) << 30;
        den = vx;
        den = den * vy;
        q = '0;
        for (int b = 15; b >= 0; b--) begin
            c = q | (17'd1 << b);
            cc = c;
            tst = den * (cc * cc);
            if (tst <= rhs) q = c;
        end
        if (q > 17'd32768) q = 17'd32768;
        if (neg) begin
            res.corr = -$signed({1'b0, q[15:0]});
            if (q == 17'd32768) res.corr = 16'sh8000;
        end else begin
            if (q > 17'd32767) q = 17'd32767;
            res.corr = q[15:0];
        end
        res.degen = 1'b0;
        return 1'b1;
    endfunction

    // offers one word, waits for the edge where it is taken, and at random then drops i_valid for a pause
    task automatic send_pair(input logic signed [SAMPLE_W-1:0] x,
                             input logic signed [SAMPLE_W-1:0] y,
                             input logic last, input bit typed, input t_corr typed_res);
        t_corr res;
        i_valid <= 1'b1;
        i_sample_x <= x;
        i_sample_y <= y;
        i_last <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (take_pair(x, y, last, res)) pending_corr.push_back(typed ? typed_res : res);
        if (!calm && $urandom_range(0, 99) < 11) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return $signed(16'($urandom_range(0, 15))) - 16'sd8;
            2: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
            default: return $signed(16'($urandom_range(0, 2000))) - 16'sd1000;
        endcase
    endfunction

    t_row plan[] = '{
        '{16'sd123, -16'sd45, 1'b1, 1'b1, 16'sd0, 1'b1},
        '{16'sd1, 16'sd1, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{16'sd2, 16'sd2, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{16'sd3, 16'sd3, 1'b1, 1'b1, 16'sd32767, 1'b0},
        '{16'sd1, -16'sd1, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{16'sd2, -16'sd2, 1'b1, 1'b1, -16'sd32768, 1'b0},
        '{16'sh7fff, 16'sh8000, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{16'sh8000, 16'sh7fff, 1'b1, 1'b1, -16'sd32768, 1'b0},
        '{16'sh8000, 16'sh8000, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{16'sh7fff, 16'sh7fff, 1'b1, 1'b1, 16'sd32767, 1'b0},
        '{16'sd5, 16'sd1, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{16'sd5, 16'sd2, 1'b1, 1'b1, 16'sd0, 1'b1},
        '{16'sd4, -16'sd9, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{-16'sd4, -16'sd9, 1'b1, 1'b1, 16'sd0, 1'b1},
        '{16'sd0, 16'sd100, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{16'sd7, -16'sd3, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{-16'sd200, 16'sd9, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{16'sh7fff, 16'sh0001, 1'b1, 1'b0, 16'sd0, 1'b0},
        '{16'shffff, 16'sh5555, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{16'sh0000, 16'shaaaa, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{16'sh1234, 16'sh8000, 1'b1, 1'b0, 16'sd0, 1'b0}
    };

    // receiver side, with one long hold-off on request
    initial begin
        i_ready = 1'b0;
        forever begin
            if (hold_req) begin
                i_ready <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_ready <= i_rst_n && (calm || $urandom_range(0, 99) >= 11);
                @(posedge i_clk);
            end
        end
    end

    // result checking and watchdog
    always @(posedge i_clk) begin
        t_corr want;
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("Regression FAIL");
                $finish;
            end
            if (o_valid && i_ready) begin
                if (pending_corr.size() == 0) begin
                    errors = errors + 1;
                    if (errors <= 10) $display("unexpected word: corr %0d degen %0b",
                                               o_correlation, o_degenerate);
                end else begin
                    want = pending_corr.pop_front();
                    if (want.corr !== o_correlation || want.degen !== o_degenerate) begin
                        errors = errors + 1;
                        if (errors <= 10)
                            $display("mismatch: corr exp %0d got %0d, degen exp %0b got %0b",
                                     want.corr, o_correlation, want.degen, o_degenerate);
                    end
                end
            end
        end
    end

    initial begin
        t_corr none;
        int sent, len, mx, my, shape, k;
        logic signed [SAMPLE_W-1:0] x, y;
        bit held;
        errors = 0;
        idle_cycles = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        held = 1'b0;
        none.corr = '0;
        none.degen = 1'b0;
        i_valid = 1'b0;
        i_sample_x = '0;
        i_sample_y = '0;
        i_last = 1'b0;
        i_rst_n = 1'b0;
        clear_sums();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            none.corr = plan[r].corr;
            none.degen = plan[r].degen;
            send_pair(plan[r].x, plan[r].y, plan[r].last, plan[r].typed, none);
        end
        none.corr = '0;
        none.degen = 1'b0;

        sent = 0;
        while (sent < 700) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
            mx = $urandom_range(0, 3);
            my = $urandom_range(0, 3);
            shape = $urandom_range(0, 3);
            k = $urandom_range(0, 6) - 3;
            for (int i = 0; i < len; i++) begin
                calm = (sent >= 200 && sent < 230);
                if (sent >= 300 && !held) begin
                    hold_req = 1'b1;
                    held = 1'b1;
                end
                x = pick_sample(mx);
                case (shape)
                    0: y = pick_sample(my);
                    1: y = (mx == 0) ? x
                                     : 16'(x * k + $signed(16'($urandom_range(0, 3))));
                    2: y = ~x;
                    default: y = pick_sample(my) + x;
                endcase
                send_pair(x, y, i == len - 1, 1'b0, none);
                sent = sent + 1;
            end
        end
        i_valid <= 1'b0;
        calm = 1'b0;

        while (pending_corr.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

@@ files.f @@
design/pc_pkg.sv
design/pc_mul.sv
design/pc_div.sv
design/pearson_correlation.sv
bench/tb.sv
